[hdl/record_sort_by_price_defines.svh]
// Assertion macros for the record sorter's RTL.
`ifndef RECORD_SORT_BY_PRICE_DEFINES_SVH
`define RECORD_SORT_BY_PRICE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RSBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsbp assertion failed");

// Next-cycle implication, checked outside reset.
`define RSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsbp assertion failed");

`else

`define RSBP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/rsbp_pkg.sv]
// Types and constants shared by the record sorter.
package rsbp_pkg;

    // Field widths of one record.
    localparam int KEY_W = 32;
    localparam int TAG_W = 8;

    // One stored record: signed price key and tag.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_rec;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_TOP_RD,
        S_TOP_LD,
        S_SCAN,
        S_TOP_WR,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

[hdl/rsbp_ifs.sv]
// Valid/ready channel interfaces for input records and sorted records.
interface rsbp_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsbp_pkg::KEY_W-1:0] price_cents;
    logic [rsbp_pkg::TAG_W-1:0]        record_tag;
    logic                              final_item;

    modport source (output valid, price_cents, record_tag, final_item, input ready);
    modport sink (input valid, price_cents, record_tag, final_item, output ready);
endinterface

interface rsbp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsbp_pkg::KEY_W-1:0] sorted_price;
    logic [rsbp_pkg::TAG_W-1:0]        sorted_tag;
    logic                              run_end;

    modport source (output valid, sorted_price, sorted_tag, run_end, input ready);
    modport sink (input valid, sorted_price, sorted_tag, run_end, output ready);
endinterface

[hdl/record_sort_by_price.sv]
// A non-final record is written to the store when it is accepted; the set is sorted after the final one.
// Sort of n records: one compare per cycle on the store's read port.
// Output: each sorted record is read, loaded and handed over; the next read waits until the sink takes the held one.
// Input ready is high only while loading; the last result may still wait during the next load.
// Reset (synchronous, active low) empties the buffer and drops any pending output.
`include "record_sort_by_price_defines.svh"

module record_sort_by_price #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsbp_in_if.sink     i_rec,
    rsbp_out_if.source  o_srt
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    rsbp_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_top_idx;
    logic [IW-1:0] r_cmp;
    logic [IW-1:0] r_oidx;
    logic          r_ovalid;
    logic          r_oend;
    rsbp_pkg::t_rec r_top;
    rsbp_pkg::t_rec r_out;

    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    rsbp_pkg::t_rec wr_data;
    logic [IW-1:0]  rd_addr;
    rsbp_pkg::t_rec rd_data;

    logic          in_acc;
    logic          room;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] n_last;
    logic          greater;
    logic          cmp_last;
    logic          out_last;

    rsbp_mem #(.DEPTH(MAX_ITEMS)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake and shared conditions.
    assign i_rec.ready = (r_state == rsbp_pkg::S_LOAD);
    assign in_acc      = i_rec.valid && i_rec.ready;
    assign room        = (r_count < MAX_CNT);
    assign cnt_next    = room ? r_count + 1'b1 : r_count;
    assign n_last      = r_n - 1'b1;
    assign greater     = (r_top.key > rd_data.key);
    assign cmp_last    = (CW'(r_cmp) == n_last);
    assign out_last    = (CW'(r_oidx) == n_last);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsbp_pkg::S_LOAD: begin
                if (in_acc && i_rec.final_item) begin
                    n_state = (cnt_next <= CW'(1)) ? rsbp_pkg::S_OUT_RD : rsbp_pkg::S_TOP_RD;
                end
            end
            rsbp_pkg::S_TOP_RD: n_state = rsbp_pkg::S_TOP_LD;
            rsbp_pkg::S_TOP_LD: n_state = rsbp_pkg::S_SCAN;
            rsbp_pkg::S_SCAN: begin
                if (cmp_last) begin
                    n_state = rsbp_pkg::S_TOP_WR;
                end
            end
            rsbp_pkg::S_TOP_WR: begin
                // The pass just finished was the last when the next top has no later entry.
                n_state = ((CW'(r_top_idx) + CW'(2)) >= r_n) ? rsbp_pkg::S_OUT_RD
                                                              : rsbp_pkg::S_TOP_RD;
            end
            rsbp_pkg::S_OUT_RD: begin
                if (!r_ovalid) begin
                    n_state = rsbp_pkg::S_OUT_LD;
                end
            end
            rsbp_pkg::S_OUT_LD: n_state = out_last ? rsbp_pkg::S_LOAD : rsbp_pkg::S_OUT_RD;
            default: n_state = rsbp_pkg::S_LOAD;
        endcase
    end

    // Store accesses for each state.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = '{key: i_rec.price_cents, tag: i_rec.record_tag};
        rd_addr = r_top_idx;
        case (r_state)
            rsbp_pkg::S_LOAD: begin
                wr_en = in_acc && room;
            end
            rsbp_pkg::S_TOP_RD: begin
                rd_addr = r_top_idx;
            end
            rsbp_pkg::S_TOP_LD: begin
                rd_addr = r_top_idx + 1'b1;
            end
            rsbp_pkg::S_SCAN: begin
                // Swap when the held top is greater: the held top record goes to the search slot.
                rd_addr = r_cmp + 1'b1;
                wr_en   = greater;
                wr_addr = r_cmp;
                wr_data = r_top;
            end
            rsbp_pkg::S_TOP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_top_idx;
                wr_data = r_top;
            end
            rsbp_pkg::S_OUT_RD: begin
                rd_addr = r_oidx;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsbp_pkg::S_LOAD;
            r_count   <= '0;
            r_n       <= '0;
            r_top_idx <= '0;
            r_cmp     <= '0;
            r_oidx    <= '0;
            r_ovalid  <= 1'b0;
            r_oend    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rsbp_pkg::S_LOAD: begin
                    if (in_acc) begin
                        if (i_rec.final_item) begin
                            r_n       <= cnt_next;
                            r_count   <= '0;
                            r_top_idx <= '0;
                            r_oidx    <= '0;
                        end else begin
                            r_count <= cnt_next;
                        end
                    end
                end
                rsbp_pkg::S_TOP_LD: r_cmp <= r_top_idx + 1'b1;
                rsbp_pkg::S_SCAN:   r_cmp <= r_cmp + 1'b1;
                rsbp_pkg::S_TOP_WR: r_top_idx <= r_top_idx + 1'b1;
                rsbp_pkg::S_OUT_LD: begin
                    r_oidx <= r_oidx + 1'b1;
                    r_oend <= out_last;
                end
                default: r_cmp <= r_cmp;
            endcase
            // Output register valid: set on load, cleared when the transaction completes.
            if (r_state == rsbp_pkg::S_OUT_LD) begin
                r_ovalid <= 1'b1;
            end else if (o_srt.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Record registers: held top record and output record.
    always_ff @(posedge i_clk) begin
        if (r_state == rsbp_pkg::S_TOP_LD) begin
            r_top <= rd_data;
        end else if (r_state == rsbp_pkg::S_SCAN && greater) begin
            r_top <= rd_data;
        end
        if (r_state == rsbp_pkg::S_OUT_LD) begin
            r_out <= rd_data;
        end
    end

    assign o_srt.valid        = r_ovalid;
    assign o_srt.sorted_price = r_out.key;
    assign o_srt.sorted_tag   = r_out.tag;
    assign o_srt.run_end      = r_oend;

    // Checks on the sequencer.
    `RSBP_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT)
    `RSBP_ASSERT_NOW(a_out_empty_on_load, i_clk, i_rst_n, r_state == rsbp_pkg::S_OUT_LD, !r_ovalid)
    `RSBP_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == rsbp_pkg::S_SCAN, CW'(r_cmp) < r_n)
    `RSBP_ASSERT_NEXT(a_last_out_ends, i_clk, i_rst_n, r_state == rsbp_pkg::S_OUT_LD && out_last, r_state == rsbp_pkg::S_LOAD && r_oend)

endmodule

[hdl/rsbp_mem.sv]
// Record store: one write port, one read port with registered read data.
module rsbp_mem #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  rsbp_pkg::t_rec           i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output rsbp_pkg::t_rec           o_rd_data
);

    rsbp_pkg::t_rec r_mem [DEPTH];
    rsbp_pkg::t_rec r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
